// ===== src/rbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_pkg: shared definitions for the region box blur core
// Register indexes, reset values, default parameter values and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbb_pkg;

    // Fixed field widths
    localparam int POS_BITS      = 6;   // out_row / out_col
    localparam int DIM_BITS      = 7;   // image_rows / image_cols
    localparam int REGION_BITS   = 6;   // region corner registers
    localparam int CFG_DATA_BITS = 7;   // widest register
    localparam int CFG_IDX_BITS  = 3;
    localparam int CNT_BITS      = 4;   // window cell count, 1 to 9

    // Default parameter values
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int DEF_FRAC_BITS  = 8;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_ROWS       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_COLS       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_ROW_FIRST = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_COL_FIRST = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_ROW_LAST  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_COL_LAST  = 3'd5;

    // Register reset values
    localparam logic [DIM_BITS-1:0]    RST_IMAGE_ROWS  = 7'd64;
    localparam logic [DIM_BITS-1:0]    RST_IMAGE_COLS  = 7'd64;
    localparam logic [REGION_BITS-1:0] RST_REGION_FIRST = 6'd0;
    localparam logic [REGION_BITS-1:0] RST_REGION_LAST  = 6'd63;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch the input request, read the line stores
        logic load;       // shift window, update line stores, plan results
        logic pick;       // take the next planned result
        logic acc_step;   // add one window cell
        logic div_start;  // start the mean division
        logic out_load;   // move the result into the output register
    } rbb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emask_empty; // no results left for this request
        logic in_region;   // current result is averaged
        logic acc_last;    // last window cell this cycle
        logic div_done;    // quotient ready
        logic out_free;    // output register can take a result
    } rbb_sts_t;

endpackage

// ===== src/rbb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/rbb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_div: sequential mean divider
// Divides (sum << FRAC_BITS) by a small count, truncating toward zero.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbb_div
    import rbb_pkg::*;
#(
    parameter int SUM_BITS  = 20,
    parameter int FRAC_BITS = 8,
    parameter int OUT_BITS  = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SUM_BITS-1:0] sum,
    input  logic [CNT_BITS-1:0]        divisor,
    output logic                       done,
    output logic [OUT_BITS-1:0]        quotient
);

    localparam int MAG_BITS  = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS = $clog2(MAG_BITS + 1);

    logic [SUM_BITS-1:0]  mag;
    logic [MAG_BITS-1:0]  quo_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]  dvs_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [CNT_BITS:0]    trial;
    logic                 fits;
    logic [MAG_BITS-1:0]  signed_quo;

    // magnitude of the dividend
    assign mag = sum[SUM_BITS-1] ? (~sum + 1'b1) : sum;

    // one restoring step
    assign trial = {rem_reg, quo_reg[MAG_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_BITS'(MAG_BITS);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= MAG_BITS'(mag) << FRAC_BITS;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= sum[SUM_BITS-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[MAG_BITS-2:0], fits};
            rem_reg <= fits ? CNT_BITS'(trial - {1'b0, dvs_reg}) : trial[CNT_BITS-1:0];
        end
    end

    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[OUT_BITS-1:0];
    assign done       = done_reg;

endmodule

// ===== src/rbb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_datapath: line stores, window, accumulator and output register
// Holds configuration, position counters, the two line stores, the 3x3
// window, the result planner, the cell accumulator and the mean divider.
// ----------------------------------------------------------------------------
module rbb_datapath
    import rbb_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_wdata,
    input  rbb_cmd_t                        cmd,
    output rbb_sts_t                        sts,
    input  logic [PIXEL_BITS-1:0]           pixel_in,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [PIXEL_BITS+FRAC_BITS-1:0] out_pixel,
    output logic [POS_BITS-1:0]             out_row,
    output logic [POS_BITS-1:0]             out_col,
    output logic                            out_last,
    output logic                            out_done
);

    localparam int CB       = $clog2(MAX_COLS);
    localparam int RB       = $clog2(MAX_ROWS);
    localparam int SUM_BITS = PIXEL_BITS + 4;
    localparam int OUT_BITS = PIXEL_BITS + FRAC_BITS;

    // configuration registers
    logic [DIM_BITS-1:0]    image_rows_reg;
    logic [DIM_BITS-1:0]    image_cols_reg;
    logic [REGION_BITS-1:0] region_row_first_reg;
    logic [REGION_BITS-1:0] region_col_first_reg;
    logic [REGION_BITS-1:0] region_row_last_reg;
    logic [REGION_BITS-1:0] region_col_last_reg;

    // position and request state
    logic [RB-1:0]         row_cnt_reg;
    logic [CB-1:0]         col_cnt_reg;
    logic [RB-1:0]         last_row;
    logic [CB-1:0]         last_col;
    logic [RB-1:0]         cur_row;
    logic [CB-1:0]         cur_col;
    logic [RB-1:0]         r_reg;
    logic [CB-1:0]         c_reg;
    logic [PIXEL_BITS-1:0] px_reg;

    // line stores and window
    logic [PIXEL_BITS-1:0]        prev_rdata;
    logic [PIXEL_BITS-1:0]        prev2_rdata;
    logic signed [PIXEL_BITS-1:0] win_reg [3][3];

    // result planning
    logic [3:0]    emask_reg;
    logic [3:0]    emask_new;
    logic [3:0]    pick_bit;
    logic          pick_dr;
    logic          pick_dc;
    logic [RB-1:0] pick_row;
    logic [CB-1:0] pick_col;
    logic          pick_in_region;
    logic          dr_reg;
    logic          dc_reg;
    logic [RB-1:0] orow_reg;
    logic [CB-1:0] ocol_reg;
    logic          in_region_reg;
    logic          last_reg;
    logic          done_flag_reg;

    // accumulation
    logic [2:0]                   row_ok;
    logic [2:0]                   col_ok;
    logic [1:0]                   n_rows;
    logic [1:0]                   n_cols;
    logic [CNT_BITS-1:0]          div_cnt;
    logic [1:0]                   ci_reg;
    logic [1:0]                   cj_reg;
    logic signed [PIXEL_BITS-1:0] cell_val;
    logic signed [SUM_BITS-1:0]   acc_reg;
    logic signed [PIXEL_BITS-1:0] center_reg;

    // division and output
    logic                div_done;
    logic [OUT_BITS-1:0] div_q;
    logic [OUT_BITS-1:0] result;
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_pixel_reg;
    logic [POS_BITS-1:0] out_row_reg;
    logic [POS_BITS-1:0] out_col_reg;
    logic                out_last_reg;
    logic                out_done_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg       <= RST_IMAGE_ROWS;
            image_cols_reg       <= RST_IMAGE_COLS;
            region_row_first_reg <= RST_REGION_FIRST;
            region_col_first_reg <= RST_REGION_FIRST;
            region_row_last_reg  <= RST_REGION_LAST;
            region_col_last_reg  <= RST_REGION_LAST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_ROWS:       image_rows_reg       <= cfg_wdata;
                CFG_IMAGE_COLS:       image_cols_reg       <= cfg_wdata;
                CFG_REGION_ROW_FIRST: region_row_first_reg <= cfg_wdata[REGION_BITS-1:0];
                CFG_REGION_COL_FIRST: region_col_first_reg <= cfg_wdata[REGION_BITS-1:0];
                CFG_REGION_ROW_LAST:  region_row_last_reg  <= cfg_wdata[REGION_BITS-1:0];
                CFG_REGION_COL_LAST:  region_col_last_reg  <= cfg_wdata[REGION_BITS-1:0];
                default: ;
            endcase
        end
    end

    // last row and column, size clamped to 1..MAX
    always_comb begin
        if (image_rows_reg == '0) begin
            last_row = '0;
        end else if (int'(image_rows_reg) > MAX_ROWS) begin
            last_row = RB'(MAX_ROWS - 1);
        end else begin
            last_row = RB'(image_rows_reg - 7'd1);
        end
        if (image_cols_reg == '0) begin
            last_col = '0;
        end else if (int'(image_cols_reg) > MAX_COLS) begin
            last_col = CB'(MAX_COLS - 1);
        end else begin
            last_col = CB'(image_cols_reg - 7'd1);
        end
    end

    // counters pulled back inside a shrunken image
    assign cur_row = (row_cnt_reg > last_row) ? last_row : row_cnt_reg;
    assign cur_col = (col_cnt_reg > last_col) ? last_col : col_cnt_reg;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg <= pixel_in;
            r_reg  <= cur_row;
            c_reg  <= cur_col;
        end
    end

    // line stores: read on accept, written back during load
    rbb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_prev (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (c_reg),
        .wdata (px_reg),
        .raddr (cur_col),
        .rdata (prev_rdata)
    );

    rbb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_prev2 (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (c_reg),
        .wdata (prev_rdata),
        .raddr (cur_col),
        .rdata (prev2_rdata)
    );

    // window shift
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= prev2_rdata;
            win_reg[1][2] <= prev_rdata;
            win_reg[2][2] <= px_reg;
        end
    end

    // results caused by this request, bit 0 first
    assign emask_new[0] = (r_reg != '0) && (c_reg != '0);
    assign emask_new[1] = (r_reg != '0) && (c_reg == last_col);
    assign emask_new[2] = (r_reg == last_row) && (c_reg != '0);
    assign emask_new[3] = (r_reg == last_row) && (c_reg == last_col);

    // position counters and plan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            emask_reg   <= '0;
        end else if (cmd.load) begin
            emask_reg <= emask_new;
            if (c_reg >= last_col) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (r_reg >= last_row) ? '0 : r_reg + 1'b1;
            end else begin
                col_cnt_reg <= c_reg + 1'b1;
            end
        end else if (cmd.pick) begin
            emask_reg <= emask_reg & ~pick_bit;
        end
    end

    // next result: offset from the window corner
    always_comb begin
        pick_bit = '0;
        pick_dr  = 1'b0;
        pick_dc  = 1'b0;
        if (emask_reg[0]) begin
            pick_bit = 4'b0001;
            pick_dr  = 1'b1;
            pick_dc  = 1'b1;
        end else if (emask_reg[1]) begin
            pick_bit = 4'b0010;
            pick_dr  = 1'b1;
        end else if (emask_reg[2]) begin
            pick_bit = 4'b0100;
            pick_dc  = 1'b1;
        end else if (emask_reg[3]) begin
            pick_bit = 4'b1000;
        end
    end

    assign pick_row = r_reg - RB'(pick_dr);
    assign pick_col = c_reg - CB'(pick_dc);

    // region test; the rows and columns are already inside the image
    assign pick_in_region = (int'(pick_row) >= int'(region_row_first_reg))
                         && (int'(pick_row) <= int'(region_row_last_reg))
                         && (int'(pick_col) >= int'(region_col_first_reg))
                         && (int'(pick_col) <= int'(region_col_last_reg));

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            dr_reg        <= pick_dr;
            dc_reg        <= pick_dc;
            orow_reg      <= pick_row;
            ocol_reg      <= pick_col;
            in_region_reg <= pick_in_region;
            last_reg      <= (emask_reg & ~pick_bit) == '0;
            done_flag_reg <= (pick_row == last_row) && (pick_col == last_col);
        end
    end

    // window rows and columns that take part in the mean
    assign row_ok[0] = dr_reg && (int'(r_reg) >= 2);
    assign row_ok[1] = r_reg != '0;
    assign row_ok[2] = 1'b1;
    assign col_ok[0] = dc_reg && (int'(c_reg) >= 2);
    assign col_ok[1] = c_reg != '0;
    assign col_ok[2] = 1'b1;

    assign n_rows  = 2'd1 + 2'(row_ok[0]) + 2'(row_ok[1]);
    assign n_cols  = 2'd1 + 2'(col_ok[0]) + 2'(col_ok[1]);
    assign div_cnt = CNT_BITS'({2'b00, n_rows} * {2'b00, n_cols});

    // walk the window one cell a cycle; the centre is caught on the way
    assign cell_val = win_reg[ci_reg][cj_reg];

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            ci_reg  <= '0;
            cj_reg  <= '0;
            acc_reg <= '0;
        end else if (cmd.acc_step) begin
            if (row_ok[ci_reg] && col_ok[cj_reg]) begin
                acc_reg <= acc_reg + SUM_BITS'(cell_val);
            end
            if (ci_reg == (dr_reg ? 2'd1 : 2'd2) && cj_reg == (dc_reg ? 2'd1 : 2'd2)) begin
                center_reg <= cell_val;
            end
            if (cj_reg == 2'd2) begin
                cj_reg <= '0;
                ci_reg <= ci_reg + 1'b1;
            end else begin
                cj_reg <= cj_reg + 1'b1;
            end
        end
    end

    rbb_div #(
        .SUM_BITS  (SUM_BITS),
        .FRAC_BITS (FRAC_BITS),
        .OUT_BITS  (OUT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .sum      (acc_reg),
        .divisor  (div_cnt),
        .done     (div_done),
        .quotient (div_q)
    );

    // averaged or passed through
    assign result = in_region_reg ? div_q : (OUT_BITS'(center_reg) << FRAC_BITS);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_pixel_reg <= result;
            out_row_reg   <= POS_BITS'(orow_reg);
            out_col_reg   <= POS_BITS'(ocol_reg);
            out_last_reg  <= last_reg;
            out_done_reg  <= done_flag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

    // status
    assign sts.emask_empty = emask_reg == '0;
    assign sts.in_region   = in_region_reg;
    assign sts.acc_last    = (ci_reg == 2'd2) && (cj_reg == 2'd2);
    assign sts.div_done    = div_done;
    assign sts.out_free    = !out_valid_reg || out_ready;

`ifndef SYNTH
    // each pick retires exactly one planned result
    a_pick_retires_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pick |=> ($countones(emask_reg) + 1 == $countones($past(emask_reg))))
        else $error("pick did not retire exactly one result");

    // the flag on a loaded result matches what is left of the plan
    a_last_matches_plan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (out_last == (emask_reg == '0)))
        else $error("last flag disagrees with remaining results");

    // a mean never divides by zero
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (div_cnt != '0))
        else $error("zero cell count at division start");
`endif

endmodule

// ===== src/rbb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_ctrl: sequencer for the region box blur core
// Takes one request at a time, updates the line stores and window, then
// steps through the results that the request causes.
// ----------------------------------------------------------------------------
module rbb_ctrl
    import rbb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  rbb_sts_t sts,
    output rbb_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_PICK = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_DIVS = 3'd4;
    localparam logic [2:0] ST_DIVW = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (sts.emask_empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.pick   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc_step = 1'b1;
                if (sts.acc_last) begin
                    state_next = sts.in_region ? ST_DIVS : ST_EMIT;
                end
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (sts.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_PICK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // an accepted request always goes on to the line store update
    a_accept_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_LOAD))
        else $error("accepted request not followed by load");

    // the divider only finishes while its result is awaited
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sts.div_done) |-> (state_reg == ST_DIVW))
        else $error("divider finished outside the wait state");
`endif

endmodule

// ===== src/region_box_blur_3x3_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_box_blur_3x3_core: 3x3 mean filter restricted to a rectangle
// Streaming top level: controller, datapath and configuration port.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_ channel, one request per pixel.
// Inside the configured rectangle each result is the mean of the pixel and
// its in-image neighbours (1, 2, 3, 4, 6 or 9 values) in signed fixed point
// with FRAC_BITS fraction bits, truncated toward zero; outside it the pixel
// is passed through, scaled. A pixel causes zero to four results, lagging by
// one row and one column; m_tlast marks the last result of a request and
// m_tuser the bottom-right pixel of the image. The core works on one request
// at a time and takes no new pixel until every result of the last one has
// entered the output register. Each result walks the window cell by cell;
// an averaged result then passes through the one-bit-per-cycle mean divider.
// The user must make configuration writes only while the core is idle; the
// core itself does not enforce this.
// ----------------------------------------------------------------------------
module region_box_blur_3x3_core
    import rbb_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]                cfg_index,
    input  logic [CFG_DATA_BITS-1:0]               cfg_wdata,
    // input pixels
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // pixel_in
    // results
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((PIXEL_BITS + FRAC_BITS + 2 * POS_BITS + 7) / 8) * 8 - 1:0]
                                                   m_tdata,  // pixel_out, out_row, out_col
    output logic                                   m_tlast,  // run_last
    output logic                                   m_tuser   // image_done
);

    localparam int OUT_BITS  = PIXEL_BITS + FRAC_BITS;
    localparam int M_DATA_W  = ((OUT_BITS + 2 * POS_BITS + 7) / 8) * 8;

    rbb_cmd_t            cmd;
    rbb_sts_t            sts;
    logic [OUT_BITS-1:0] pixel_out;
    logic [POS_BITS-1:0] out_row;
    logic [POS_BITS-1:0] out_col;

    rbb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rbb_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .pixel_in  (s_tdata[PIXEL_BITS-1:0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_pixel (pixel_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

    // result fields packed from the lowest bit up
    assign m_tdata = M_DATA_W'({out_col, out_row, pixel_out});

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for region_box_blur_3x3_core
// Streams pixels in raster order through the core and compares every result
// with a cycle-free model of the region mean filter kept in the bench. A short
// table of directed steps (size and region extremes, sizes of zero, a clipped
// region, a size cut mid-image, single-row images) is followed by random
// images with random sizes and regions, under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import rbb_pkg::*;

    localparam int MAX_COLS     = DEF_MAX_COLS;
    localparam int MAX_ROWS     = DEF_MAX_ROWS;
    localparam int FRAC_BITS    = DEF_FRAC_BITS;
    localparam int S_BITS       = ((DEF_PIXEL_BITS + 7) / 8) * 8;
    localparam int M_BITS       = ((DEF_PIXEL_BITS + FRAC_BITS + 2 * POS_BITS + 7) / 8) * 8;
    localparam int RAND_ITEMS   = 180;
    localparam int DRAIN_CYCLES = 200;      // beyond one request with four mean results
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [23:0] pixel_out;
        logic [5:0]  out_row;
        logic [5:0]  out_col;
        logic        run_last;
        logic        image_done;
    } blur_res_t;

    typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_PIX_KNOWN} step_kind_e;

    typedef struct {
        step_kind_e                 kind;
        logic [CFG_IDX_BITS-1:0]    idx;
        logic [15:0]                val;
        logic [23:0]                known_pix;  // 1x1 images only
    } dir_step_t;

    localparam int DIR_STEPS = 40;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]    cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [S_BITS-1:0]          s_tdata;    // pixel_in
    logic                       m_tvalid;
    logic                       m_tready;
    logic [M_BITS-1:0]          m_tdata;    // pixel_out, out_row, out_col
    logic                       m_tlast;    // run_last
    logic                       m_tuser;    // image_done

    // Mirror of the core state
    logic signed [15:0] line_up1 [MAX_COLS];
    logic signed [15:0] line_up2 [MAX_COLS];
    logic signed [15:0] win [3][3];
    int                 pos_row;
    int                 pos_col;
    logic [6:0]         cfg_rows;
    logic [6:0]         cfg_cols;
    logic [5:0]         reg_r0;
    logic [5:0]         reg_c0;
    logic [5:0]         reg_r1;
    logic [5:0]         reg_c1;

    blur_res_t  expected_px [$];
    int         errors;
    bit         steady;
    longint     cycles;

    dir_step_t dir_tbl [DIR_STEPS] = '{
        // 1x1 image (sizes of zero act as one): mean of one value
        '{STEP_CFG,       CFG_IMAGE_ROWS,       16'd0,    24'd0},
        '{STEP_CFG,       CFG_IMAGE_COLS,       16'd0,    24'd0},
        '{STEP_PIX_KNOWN, 3'd0,                 16'h8000, 24'h800000},
        '{STEP_PIX_KNOWN, 3'd0,                 16'h7FFF, 24'h7FFF00},
        '{STEP_PIX_KNOWN, 3'd0,                 16'hFFFF, 24'hFFFF00},
        // empty region: pass-through
        '{STEP_CFG,       CFG_REGION_ROW_FIRST, 16'd1,    24'd0},
        '{STEP_PIX_KNOWN, 3'd0,                 16'h5A5A, 24'h5A5A00},
        // 3x3 image, full region: 4, 6 and 9 cell means
        '{STEP_CFG,       CFG_IMAGE_ROWS,       16'd3,    24'd0},
        '{STEP_CFG,       CFG_IMAGE_COLS,       16'd3,    24'd0},
        '{STEP_CFG,       CFG_REGION_ROW_FIRST, 16'd0,    24'd0},
        '{STEP_PIX,       3'd0,                 16'h7FFF, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8000, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8000, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h7FFF, 24'd0},
        '{STEP_PIX,       3'd0,                 16'hFFFF, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8000, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h0001, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h7FFF, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8000, 24'd0},
        // 3x4 image, region clipped to the image, then columns cut mid-image
        '{STEP_CFG,       CFG_IMAGE_COLS,       16'd4,    24'd0},
        '{STEP_CFG,       CFG_REGION_ROW_FIRST, 16'd1,    24'd0},
        '{STEP_CFG,       CFG_REGION_COL_FIRST, 16'd2,    24'd0},
        '{STEP_PIX,       3'd0,                 16'h1234, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8000, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h7FFF, 24'd0},
        '{STEP_PIX,       3'd0,                 16'hFF00, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h00FF, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8001, 24'd0},
        '{STEP_CFG,       CFG_IMAGE_COLS,       16'd2,    24'd0},
        '{STEP_PIX,       3'd0,                 16'h7FFE, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8000, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h0003, 24'd0},
        // single row image, one-column region
        '{STEP_CFG,       CFG_IMAGE_ROWS,       16'd1,    24'd0},
        '{STEP_CFG,       CFG_IMAGE_COLS,       16'd3,    24'd0},
        '{STEP_CFG,       CFG_REGION_ROW_FIRST, 16'd0,    24'd0},
        '{STEP_CFG,       CFG_REGION_COL_FIRST, 16'd1,    24'd0},
        '{STEP_CFG,       CFG_REGION_COL_LAST,  16'd1,    24'd0},
        '{STEP_PIX,       3'd0,                 16'h7FFF, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h8000, 24'd0},
        '{STEP_PIX,       3'd0,                 16'h4321, 24'd0}
    };

    region_box_blur_3x3_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Size register as the core sees it: zero acts as one, clipped to the max
    function automatic int dim_eff(input logic [6:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    // One result for (orow, ocol); the window's newest cell is image (r, c)
    function automatic void add_blur_result(input int orow, input int ocol, input int r,
                                            input int c, input int rows, input int cols);
        int        rl;
        int        cl;
        int        ir;
        int        jc;
        int        i;
        int        j;
        longint    acc;
        longint    cnt;
        longint    val;
        blur_res_t res;
        rl = (int'(reg_r1) > rows - 1) ? rows - 1 : int'(reg_r1);
        cl = (int'(reg_c1) > cols - 1) ? cols - 1 : int'(reg_c1);
        if (orow >= int'(reg_r0) && orow <= rl && ocol >= int'(reg_c0) && ocol <= cl) begin
            acc = 0;
            cnt = 0;
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    ir = r - 2 + i;
                    jc = c - 2 + j;
                    if (ir >= 0 && ir < rows && jc >= 0 && jc < cols &&
                        ir >= orow - 1 && ir <= orow + 1 &&
                        jc >= ocol - 1 && jc <= ocol + 1) begin
                        acc += win[i][j];
                        cnt++;
                    end
                end
            end
            if (cnt == 0) cnt = 1;
            // integer division truncates toward zero
            val = (acc * (longint'(1) << FRAC_BITS)) / cnt;
        end else begin
            val = longint'(win[2 - (r - orow)][2 - (c - ocol)]) * (longint'(1) << FRAC_BITS);
        end
        res.pixel_out  = val[23:0];
        res.out_row    = orow[5:0];
        res.out_col    = ocol[5:0];
        res.run_last   = 1'b0;
        res.image_done = (orow == rows - 1 && ocol == cols - 1);
        expected_px.push_back(res);
    endfunction

    // Advance the mirror by one accepted pixel and queue the results it causes
    function automatic void predict_blur(input logic signed [15:0] px);
        int rows;
        int cols;
        int r;
        int c;
        int i;
        int n0;
        rows = dim_eff(cfg_rows, MAX_ROWS);
        cols = dim_eff(cfg_cols, MAX_COLS);
        if (pos_row >= rows) pos_row = rows - 1;
        if (pos_col >= cols) pos_col = cols - 1;
        r = pos_row;
        c = pos_col;
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_up2[c];
        win[1][2] = line_up1[c];
        win[2][2] = px;
        line_up2[c] = line_up1[c];
        line_up1[c] = px;

        n0 = expected_px.size();
        if (r >= 1 && c >= 1) add_blur_result(r - 1, c - 1, r, c, rows, cols);
        if (r >= 1 && c == cols - 1) add_blur_result(r - 1, c, r, c, rows, cols);
        if (r == rows - 1 && c >= 1) add_blur_result(r, c - 1, r, c, rows, cols);
        if (r == rows - 1 && c == cols - 1) add_blur_result(r, c, r, c, rows, cols);
        if (expected_px.size() > n0) expected_px[expected_px.size() - 1].run_last = 1'b1;

        if (c >= cols - 1) begin
            pos_col = 0;
            pos_row = (r >= rows - 1) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endfunction

    // Offer one pixel request; called and returns at a falling edge
    task automatic send_pixel(input logic [15:0] px, input bit known,
                              input logic [23:0] known_pix);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        predict_blur(px);
        // 1x1 image: exactly one result, known without the mirror
        if (known)
            expected_px[expected_px.size() - 1] = '{known_pix, 6'd0, 6'd0, 1'b1, 1'b1};
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [6:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_IMAGE_ROWS:       cfg_rows = val;
            CFG_IMAGE_COLS:       cfg_cols = val;
            CFG_REGION_ROW_FIRST: reg_r0 = val[5:0];
            CFG_REGION_COL_FIRST: reg_c0 = val[5:0];
            CFG_REGION_ROW_LAST:  reg_r1 = val[5:0];
            CFG_REGION_COL_LAST:  reg_c1 = val[5:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Hold off requests until every result is out and the core has gone quiet
    task automatic drain_core();
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Result side backpressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // Result checker
    always @(posedge aclk) begin
        blur_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_px.size() == 0) begin
                $error("unexpected result: row %0d col %0d", m_tdata[29:24], m_tdata[35:30]);
                errors++;
            end else begin
                want = expected_px.pop_front();
                if (m_tdata[23:0] !== want.pixel_out) begin
                    $error("pixel_out: expected %0d, actual %0d",
                           $signed(want.pixel_out), $signed(m_tdata[23:0]));
                    errors++;
                end
                if (m_tdata[29:24] !== want.out_row) begin
                    $error("out_row: expected %0d, actual %0d", want.out_row, m_tdata[29:24]);
                    errors++;
                end
                if (m_tdata[35:30] !== want.out_col) begin
                    $error("out_col: expected %0d, actual %0d", want.out_col, m_tdata[35:30]);
                    errors++;
                end
                if (m_tlast !== want.run_last) begin
                    $error("run_last: expected %0d, actual %0d", want.run_last, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.image_done) begin
                    $error("image_done: expected %0d, actual %0d", want.image_done, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int          k;
        int          img;
        int          rand_sent;
        int          img_sent;
        int          cut;
        int          big_v;
        logic [6:0]  rows_v;
        logic [6:0]  cols_v;
        logic [15:0] px;

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        errors    = 0;
        cycles    = 0;
        steady    = 1'b0;
        line_up1  = '{default: '0};
        line_up2  = '{default: '0};
        win       = '{default: '{default: '0}};
        pos_row   = 0;
        pos_col   = 0;
        cfg_rows  = RST_IMAGE_ROWS;
        cfg_cols  = RST_IMAGE_COLS;
        reg_r0    = RST_REGION_FIRST;
        reg_c0    = RST_REGION_FIRST;
        reg_r1    = RST_REGION_LAST;
        reg_c1    = RST_REGION_LAST;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        for (k = 0; k < DIR_STEPS; k++) begin
            if (dir_tbl[k].kind == STEP_CFG) begin
                if (k == 0 || dir_tbl[k - 1].kind != STEP_CFG) drain_core();
                write_reg(dir_tbl[k].idx, dir_tbl[k].val[6:0]);
            end else begin
                send_pixel(dir_tbl[k].val, dir_tbl[k].kind == STEP_PIX_KNOWN,
                           dir_tbl[k].known_pix);
            end
        end

        // Random images; one stretch runs with no stalls on either side
        img = 0;
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            drain_core();
            steady = (rand_sent >= 60 && rand_sent < 120);

            // mostly small images, now and then one at full length
            if (img == 0 || $urandom_range(0, 99) < 8) begin
                case ($urandom_range(0, 2))
                    0:       big_v = 64;
                    1:       big_v = 127;
                    default: big_v = $urandom_range(65, 126);
                endcase
                if ($urandom_range(0, 1)) begin
                    rows_v = 7'(big_v);
                    cols_v = 7'($urandom_range(0, 1));
                end else begin
                    rows_v = 7'($urandom_range(0, 1));
                    cols_v = 7'(big_v);
                end
            end else begin
                rows_v = 7'($urandom_range(0, 6));
                cols_v = 7'($urandom_range(0, 6));
            end
            write_reg(CFG_IMAGE_ROWS, rows_v);
            write_reg(CFG_IMAGE_COLS, cols_v);

            // region corners; bit 6 carries junk the core must drop
            write_reg(CFG_REGION_ROW_FIRST, {1'($urandom_range(0, 1)),
                      ($urandom_range(0, 9) == 0) ? 6'd63 : 6'($urandom_range(0, 5))});
            write_reg(CFG_REGION_COL_FIRST, {1'($urandom_range(0, 1)),
                      ($urandom_range(0, 9) == 0) ? 6'd63 : 6'($urandom_range(0, 5))});
            write_reg(CFG_REGION_ROW_LAST, {1'($urandom_range(0, 1)),
                      ($urandom_range(0, 6) == 0) ? 6'd63 :
                      ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(0, 6))});
            write_reg(CFG_REGION_COL_LAST, {1'($urandom_range(0, 1)),
                      ($urandom_range(0, 6) == 0) ? 6'd63 :
                      ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(0, 6))});

            // sometimes cut one dimension part way through the image
            k = dim_eff(cfg_rows, MAX_ROWS) * dim_eff(cfg_cols, MAX_COLS);
            cut = (k >= 4 && $urandom_range(0, 3) == 0) ? $urandom_range(1, k - 1) : 0;
            img_sent = 0;
            do begin
                if (cut != 0 && img_sent == cut) begin
                    drain_core();
                    if ($urandom_range(0, 1))
                        write_reg(CFG_IMAGE_COLS,
                                  7'($urandom_range(0, dim_eff(cfg_cols, MAX_COLS) - 1)));
                    else
                        write_reg(CFG_IMAGE_ROWS,
                                  7'($urandom_range(0, dim_eff(cfg_rows, MAX_ROWS) - 1)));
                end
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       px = 16'h8000;
                        1:       px = 16'h7FFF;
                        2:       px = 16'h0000;
                        default: px = 16'hFFFF;
                    endcase
                end else begin
                    px = 16'($urandom());
                end
                send_pixel(px, 1'b0, 24'd0);
                img_sent++;
                rand_sent++;
            end while (pos_row != 0 || pos_col != 0);
            img++;
        end

        steady = 1'b0;
        drain_core();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
